// ===== rtl/double_ended_queue_unit_defines.svh =====
// assertion macros shared by the double-ended queue rtl
`ifndef DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH

// condition holds at every clock edge out of reset
`define DEQ_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define DEQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/deq_pkg.sv =====
// types and constants of the double-ended queue unit
`timescale 1ns / 1ps

package deq_pkg;

    localparam int DEQ_DEPTH      = 16;
    localparam int DEQ_DATA_WIDTH = 32;

    localparam int ACTION_W      = 3;
    localparam int VALUE_W       = 32;
    localparam int INDEX_W       = 4;
    localparam int READ_DATA_W   = 32;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_COUNT_W = 5;

    localparam int S_TDATA_W = ((VALUE_W + INDEX_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((READ_DATA_W + STATUS_W + ENTRY_COUNT_W + 7) / 8) * 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_BACK  = 3'd0,
        ACT_PUSH_FRONT = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_PEEK_FRONT = 3'd4,
        ACT_PEEK_BACK  = 3'd5,
        ACT_READ_INDEX = 3'd6
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_RESP = 1'b1
    } state_t;

endpackage

// ===== rtl/deq_ram.sv =====
// generic single-clock ram, one write port and one registered read port
`timescale 1ns / 1ps

module deq_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/double_ended_queue_unit.sv =====
// top level of the double-ended queue unit: ring buffer control around one ram
//
//  channel  | direction | handshake          | contents
//  ---------+-----------+--------------------+---------------------------------
//  s_       | in        | s_tvalid/s_tready  | request: action, value, index
//  m_       | out       | m_tvalid/m_tready  | result: read_data, status, count
//
// a request is accepted when s_tvalid and s_tready are both high; head, count and the ram access are settled there,
// and the ram read data is registered in the ram, then copied into the result register once m_ is free.
// with m_tready held high one request is taken every cycle; the result register
// and the registered ram read set that figure.
// a request may be accepted while an earlier result waits; it then holds until m_ drains.
// reset clears head, count and the control state; the storage needs no clearing pass.
`timescale 1ns / 1ps
`include "double_ended_queue_unit_defines.svh"

module double_ended_queue_unit
    import deq_pkg::*;
#(
    parameter int DEPTH      = DEQ_DEPTH,
    parameter int DATA_WIDTH = DEQ_DATA_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // value [31:0], index [35:32], zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // action [2:0]
    input  logic [ACTION_W-1:0]  s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // read_data [31:0], status [33:32], entry_count [38:34], zero pad
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = PTR_W + 1;
    localparam int CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam int DWIDE  = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
    localparam int CWIDE  = (CNT_W > ENTRY_COUNT_W) ? CNT_W : ENTRY_COUNT_W;
    localparam int M_PAD  = M_TDATA_W - READ_DATA_W - STATUS_W - ENTRY_COUNT_W;

    state_t                     state_reg, state_next;
    logic [PTR_W-1:0]           head_reg, head_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]       m_tdata_reg, m_tdata_next;
    status_t                    resp_status_reg, resp_status_next;
    logic                       resp_rd_reg, resp_rd_next;
    logic [ENTRY_COUNT_W-1:0]   resp_count_reg, resp_count_next;

    logic                       s_accept;
    logic                       out_free;
    action_t                    act;
    logic [VALUE_W-1:0]         in_value;
    logic [INDEX_W-1:0]         in_index;
    logic [DWIDE-1:0]           value_wide;
    logic [DWIDE-1:0]           rd_wide;
    logic [CWIDE-1:0]           count_wide;
    logic [CMP_W-1:0]           idx_cmp, cnt_cmp;
    logic [CNT_W-1:0]           cnt_dec;
    logic                       q_full, q_empty;
    logic [PTR_W-1:0]           off_sel;
    logic [PTR_W-1:0]           slot_addr;
    logic                       head_from_addr;
    logic                       do_wr, do_rd;
    status_t                    req_status;
    logic [DATA_WIDTH-1:0]      ram_rd_data;

    function automatic logic [PTR_W-1:0] slot_at(input logic [PTR_W-1:0] base,
                                                 input logic [PTR_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    assign act        = action_t'(s_tuser);
    assign in_value   = s_tdata[VALUE_W-1:0];
    assign in_index   = s_tdata[VALUE_W +: INDEX_W];
    assign value_wide = DWIDE'(in_value);
    assign idx_cmp    = CMP_W'(in_index);
    assign cnt_cmp    = CMP_W'(count_reg);
    assign cnt_dec    = count_reg - 1'b1;
    assign q_full     = (count_reg == CNT_W'(DEPTH));
    assign q_empty    = (count_reg == '0);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign s_accept   = s_tvalid && s_tready;

    // request decode: ram access, pointer and count updates
    always_comb begin
        off_sel        = '0;
        head_from_addr = 1'b0;
        do_wr          = 1'b0;
        do_rd          = 1'b0;
        req_status     = STATUS_OK;
        head_next      = head_reg;
        count_next     = count_reg;
        case (act)
            ACT_PUSH_BACK: begin
                if (q_full) begin
                    req_status = STATUS_FULL;
                end else begin
                    do_wr      = 1'b1;
                    off_sel    = count_reg[PTR_W-1:0];
                    count_next = count_reg + 1'b1;
                end
            end
            ACT_PUSH_FRONT: begin
                if (q_full) begin
                    req_status = STATUS_FULL;
                end else begin
                    do_wr          = 1'b1;
                    off_sel        = PTR_W'(DEPTH - 1);
                    head_from_addr = 1'b1;
                    count_next     = count_reg + 1'b1;
                end
            end
            ACT_POP_FRONT: begin
                if (q_empty) begin
                    req_status = STATUS_EMPTY;
                end else begin
                    do_rd      = 1'b1;
                    head_next  = slot_at(head_reg, PTR_W'(1));
                    count_next = cnt_dec;
                end
            end
            ACT_POP_BACK: begin
                if (q_empty) begin
                    req_status = STATUS_EMPTY;
                end else begin
                    do_rd      = 1'b1;
                    off_sel    = cnt_dec[PTR_W-1:0];
                    count_next = cnt_dec;
                end
            end
            ACT_PEEK_FRONT: begin
                if (q_empty) begin
                    req_status = STATUS_EMPTY;
                end else begin
                    do_rd = 1'b1;
                end
            end
            ACT_PEEK_BACK: begin
                if (q_empty) begin
                    req_status = STATUS_EMPTY;
                end else begin
                    do_rd   = 1'b1;
                    off_sel = cnt_dec[PTR_W-1:0];
                end
            end
            ACT_READ_INDEX: begin
                if (idx_cmp >= cnt_cmp) begin
                    req_status = STATUS_EMPTY;
                end else begin
                    do_rd   = 1'b1;
                    off_sel = idx_cmp[PTR_W-1:0];
                end
            end
            default: begin
                req_status = STATUS_EMPTY;
            end
        endcase
        slot_addr = slot_at(head_reg, off_sel);
        if (head_from_addr) begin
            head_next = slot_addr;
        end
    end

    assign count_wide = CWIDE'(count_next);

    deq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH),
        .ADDR_W(PTR_W)
    ) u_storage (
        .clk    (aclk),
        .wr_en  (s_accept && do_wr),
        .wr_addr(slot_addr),
        .wr_data(value_wide[DATA_WIDTH-1:0]),
        .rd_en  (s_accept && do_rd),
        .rd_addr(slot_addr),
        .rd_data(ram_rd_data)
    );

    assign rd_wide = DWIDE'(ram_rd_data);

    // handshake control and result register
    always_comb begin
        state_next       = state_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;
        resp_status_next = resp_status_reg;
        resp_rd_next     = resp_rd_reg;
        resp_count_next  = resp_count_reg;
        s_tready         = 1'b0;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
            end
            S_RESP: begin
                s_tready = out_free;
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{M_PAD{1'b0}}, resp_count_reg, resp_status_reg,
                                     resp_rd_reg ? rd_wide[READ_DATA_W-1:0]
                                                 : {READ_DATA_W{1'b0}}};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        if (s_accept) begin
            state_next       = S_RESP;
            resp_status_next = req_status;
            resp_rd_next     = do_rd;
            resp_count_next  = count_wide[ENTRY_COUNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (s_accept) begin
                head_reg  <= head_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg     <= m_tdata_next;
        resp_status_reg <= resp_status_next;
        resp_rd_reg     <= resp_rd_next;
        resp_count_reg  <= resp_count_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `DEQ_ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(DEPTH), "count above depth")
    `DEQ_ASSERT_ALWAYS(a_one_ram_access, aclk, aresetn, !(u_storage.wr_en && u_storage.rd_en), "ram read and write together")
    `DEQ_ASSERT_IMPL(a_no_result_overrun, aclk, aresetn, s_accept && (state_reg == S_RESP), out_free, "request taken while result blocked")
    `DEQ_ASSERT_NEXT(a_push_grows, aclk, aresetn, s_accept && do_wr, count_reg == $past(count_reg) + 1'b1, "push did not grow count")
    `DEQ_ASSERT_NEXT(a_refused_keeps_head, aclk, aresetn, s_accept && (req_status != STATUS_OK), $stable(head_reg) && $stable(count_reg), "refused request moved state")

endmodule

// ===== tb/sv/double_ended_queue_unit_test.sv =====
// testbench for the double-ended queue unit: random requests checked against a shadow deque
`timescale 1ns / 1ps

module double_ended_queue_unit_test;
    import deq_pkg::*;

    localparam int DEPTH          = DEQ_DEPTH;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1080;
    localparam int DRAIN_CYCLES   = 8;

    // the one action code that the package leaves without a name
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;

    typedef struct packed {
        logic [READ_DATA_W-1:0]   read_data;
        status_t                  status;
        logic [ENTRY_COUNT_W-1:0] entry_count;
    } deque_result_t;

    class deque_shadow;
        logic [DEQ_DATA_WIDTH-1:0] slots [DEPTH];
        int head;
        int held;
        int errors;
        deque_result_t pending_results[$];

        function new();
            head   = 0;
            held   = 0;
            errors = 0;
        endfunction

        // apply one accepted request and queue the result it must produce
        function void note_request(logic [ACTION_W-1:0] act, logic [VALUE_W-1:0] value,
                                   logic [INDEX_W-1:0] index);
            deque_result_t r;
            r.read_data = '0;
            r.status    = STATUS_OK;
            case (act)
                ACT_PUSH_BACK: begin
                    if (held >= DEPTH) begin
                        r.status = STATUS_FULL;
                    end else begin
                        slots[(head + held) % DEPTH] = value;
                        held++;
                    end
                end
                ACT_PUSH_FRONT: begin
                    if (held >= DEPTH) begin
                        r.status = STATUS_FULL;
                    end else begin
                        head = (head + DEPTH - 1) % DEPTH;
                        slots[head] = value;
                        held++;
                    end
                end
                ACT_POP_FRONT: begin
                    if (held == 0) begin
                        r.status = STATUS_EMPTY;
                    end else begin
                        r.read_data = slots[head];
                        head = (head + 1) % DEPTH;
                        held--;
                    end
                end
                ACT_POP_BACK: begin
                    if (held == 0) begin
                        r.status = STATUS_EMPTY;
                    end else begin
                        r.read_data = slots[(head + held - 1) % DEPTH];
                        held--;
                    end
                end
                ACT_PEEK_FRONT: begin
                    if (held == 0) r.status = STATUS_EMPTY;
                    else r.read_data = slots[head];
                end
                ACT_PEEK_BACK: begin
                    if (held == 0) r.status = STATUS_EMPTY;
                    else r.read_data = slots[(head + held - 1) % DEPTH];
                end
                ACT_READ_INDEX: begin
                    if (int'(index) >= held) r.status = STATUS_EMPTY;
                    else r.read_data = slots[(head + int'(index)) % DEPTH];
                end
                default: begin
                    r.status = STATUS_EMPTY;
                end
            endcase
            r.entry_count = held[ENTRY_COUNT_W-1:0];
            pending_results.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            $display("%0t: %s", $time, msg);
        endtask

        task check_result(logic [M_TDATA_W-1:0] tdata);
            deque_result_t exp_r;
            logic [READ_DATA_W-1:0]   got_data;
            logic [STATUS_W-1:0]      got_status;
            logic [ENTRY_COUNT_W-1:0] got_count;
            got_data   = tdata[READ_DATA_W-1:0];
            got_status = tdata[READ_DATA_W +: STATUS_W];
            got_count  = tdata[READ_DATA_W + STATUS_W +: ENTRY_COUNT_W];
            if (pending_results.size() == 0) begin
                report($sformatf("result with none pending: data %h status %0d count %0d",
                                 got_data, got_status, got_count));
            end else begin
                exp_r = pending_results.pop_front();
                if (got_data !== exp_r.read_data)
                    report($sformatf("read_data %h, expected %h", got_data, exp_r.read_data));
                if (got_status !== exp_r.status)
                    report($sformatf("status %0d, expected %0d", got_status, exp_r.status));
                if (got_count !== exp_r.entry_count)
                    report($sformatf("entry_count %0d, expected %0d",
                                     got_count, exp_r.entry_count));
            end
        endtask
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // value [31:0], index [35:32], zero pad
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    // action [2:0]
    logic [ACTION_W-1:0]  s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // read_data [31:0], status [33:32], entry_count [38:34], zero pad
    logic [M_TDATA_W-1:0] m_tdata;

    deque_shadow shadow = new();
    bit          hold_off_req = 1'b0;
    int          idle_cycles  = 0;

    double_ended_queue_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_request(logic [ACTION_W-1:0] act, logic [VALUE_W-1:0] value,
                                logic [INDEX_W-1:0] index);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(S_TDATA_W - VALUE_W - INDEX_W){1'b0}}, index, value};
        do @(posedge aclk); while (!s_tready);
        shadow.note_request(act, value, index);
    endtask

    task automatic idle_sender(int cycles);
        if (cycles > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (cycles - 1) @(negedge aclk);
        end
    endtask

    task automatic issue(logic [ACTION_W-1:0] act, logic [VALUE_W-1:0] value,
                         logic [INDEX_W-1:0] index);
        send_request(act, value, index);
        idle_sender(pick_gap());
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) shadow.check_result(m_tdata);
    end

    // receiver: random ready pattern, plus one long hold-off once the random part starts
    initial begin
        int run;
        int gap;
        wait (aresetn);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge aclk);
            end
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 8);
            @(negedge aclk);
            m_tready <= 1'b1;
            repeat (run - 1) @(negedge aclk);
            gap = pick_gap();
            if (gap > 0) begin
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("Mismatches found");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int phase;
        int r;
        bit no_gaps;
        logic [ACTION_W-1:0] act;
        logic [INDEX_W-1:0]  index;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // everything refused on an empty queue, the unused code too
        issue(ACT_POP_FRONT, 32'h0, 4'h0);
        issue(ACT_POP_BACK, 32'hFFFF_FFFF, 4'hF);
        issue(ACT_PEEK_FRONT, 32'h0, 4'h0);
        issue(ACT_PEEK_BACK, 32'h0, 4'h0);
        issue(ACT_READ_INDEX, 32'h0, 4'h0);
        issue(ACT_UNUSED, 32'hFFFF_FFFF, 4'hF);
        // value extremes at both ends
        issue(ACT_PUSH_BACK, 32'h0000_0000, 4'h0);
        issue(ACT_PUSH_FRONT, 32'hFFFF_FFFF, 4'hF);
        issue(ACT_READ_INDEX, 32'h0, 4'h1);
        issue(ACT_READ_INDEX, 32'h0, 4'h2);
        // fill up with a mix of both push actions, then one push too many each way
        for (int i = 0; i < DEPTH - 2; i++)
            issue((i % 2) ? ACT_PUSH_FRONT : ACT_PUSH_BACK, $urandom(), 4'($urandom_range(0, 15)));
        issue(ACT_PUSH_BACK, 32'hA5A5_A5A5, 4'h0);
        issue(ACT_PUSH_FRONT, 32'h5A5A_5A5A, 4'h0);
        issue(ACT_READ_INDEX, 32'h0, 4'hF);
        issue(ACT_PEEK_BACK, 32'h0, 4'h0);
        issue(ACT_UNUSED, 32'h0, 4'h0);

        // random part: fill, drain and mixed phases so both full and empty come up often
        hold_off_req = 1'b1;
        phase   = 2;
        no_gaps = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                phase   = $urandom_range(0, 2);
                no_gaps = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 2) begin
                act = ACT_UNUSED;
            end else if (phase == 0) begin
                act = (r < 70) ? 3'($urandom_range(0, 1)) : 3'($urandom_range(2, 6));
            end else if (phase == 1) begin
                act = (r < 70) ? 3'($urandom_range(2, 3)) : 3'($urandom_range(0, 6));
            end else begin
                act = 3'($urandom_range(0, 6));
            end
            index = 4'($urandom_range(0, 15));
            if (act == ACT_READ_INDEX && shadow.held > 0 && $urandom_range(0, 1))
                index = 4'($urandom_range(0, shadow.held - 1));
            send_request(act, $urandom(), index);
            if (!no_gaps) idle_sender(pick_gap());
        end

        idle_sender(1);
        while (shadow.pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        while (shadow.pending_results.size() != 0) begin
            void'(shadow.pending_results.pop_front());
            shadow.report("expected result never arrived");
        end

        if (shadow.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
